// ===== src/cpf_pkg.sv =====
`timescale 1ns / 1ps
package cpf_pkg;
	localparam int MaxPointsDefault = 64;
	localparam int CoordW = 16;
	localparam int DistW = 33;
	localparam int RootW = 17;
	localparam int StatusW = 2;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_FEW = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	typedef struct packed {
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic last_point;
	} point_word_t;

	typedef struct packed {
		logic signed [15:0] first_x;
		logic signed [15:0] first_y;
		logic signed [15:0] second_x;
		logic signed [15:0] second_y;
		logic [32:0] dist_sq;
		logic [16:0] dist_root;
		logic [1:0] status;
	} result_word_t;
endpackage

// ===== src/cpf_if.sv =====
`timescale 1ns / 1ps
interface cpf_point_if;
	logic valid;
	logic ready;
	cpf_pkg::point_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cpf_result_if;
	logic valid;
	logic ready;
	cpf_pkg::result_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== src/cpf_sqrt.sv =====
`timescale 1ns / 1ps
module cpf_sqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [32:0] value,
	output logic done,
	output logic [16:0] root
);
	import cpf_pkg::*;

	// Restoring square root, one result bit per cycle.
	logic [33:0] rem_q;
	logic [16:0] root_q;
	logic [4:0] step_q;
	logic busy_q;
	logic [18:0] trial;
	logic [35:0] rem_shift;
	logic [1:0] pair;
	logic [33:0] value_ext;

	// The operand is widened to an even width so that the top pair is in range.
	always_comb begin
		value_ext = {1'b0, value};
		pair = value_ext[2 * step_q +: 2];
		rem_shift = {rem_q, pair};
		trial = {root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 5'd16;
			end else if (busy_q) begin
				if (step_q == 5'd0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				step_q <= step_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			if (rem_shift >= 36'(trial)) begin
				rem_q <= 34'(rem_shift - 36'(trial));
				root_q <= {root_q[15:0], 1'b1};
			end else begin
				rem_q <= rem_shift[33:0];
				root_q <= {root_q[15:0], 1'b0};
			end
		end
	end

	assign root = root_q;
endmodule

// ===== src/closest_pair_finder.sv =====
`timescale 1ns / 1ps
// Points load one per cycle while ready is high, into the point memory, which has one write
// and two read ports. After the last point the set is closed, then every pair is scanned at
// one pair per cycle, the pipeline drains, the best pair is fetched and its square root taken.
// If N < 2 no scan runs and the result word carries STATUS_FEW.
// Input is held off from the last point until the result word is taken.
// Reset (arst_n low) clears the counters and control; the memory is not cleared.
module closest_pair_finder #(
	parameter int MAX_POINTS = cpf_pkg::MaxPointsDefault
) (
	input logic clk,
	input logic arst_n,
	cpf_point_if.sink points,
	cpf_result_if.source result
);
	import cpf_pkg::*;

	localparam int IdxW = $clog2(MAX_POINTS);
	localparam int CntW = $clog2(MAX_POINTS + 1);

	typedef enum logic [5:0] {
		ST_LOAD = 6'b000001,
		ST_SCAN = 6'b000010,
		ST_DRAIN = 6'b000100,
		ST_FETCH = 6'b001000,
		ST_ROOT = 6'b010000,
		ST_OUT = 6'b100000
	} state_t;

	state_t state_q;
	logic [31:0] mem [MAX_POINTS];
	logic [31:0] rd_a_s1, rd_b_s1;
	logic [IdxW-1:0] addr_a, addr_b;
	logic [CntW-1:0] count_q;
	logic overflow_q;
	logic [IdxW-1:0] i_q, j_q;
	logic pv_s1, pv_s2;
	logic [IdxW-1:0] pi_s1, pj_s1, pi_s2, pj_s2;
	logic [32:0] dsq_s2;
	logic [33:0] best_q;
	logic [IdxW-1:0] best_i_q, best_j_q;
	logic [2:0] drain_q;
	logic root_start, root_done;
	logic [16:0] root;
	logic out_valid_q;
	result_word_t out_q;
	logic accept;
	logic signed [16:0] dx, dy;
	logic [16:0] ax, ay;
	logic [1:0] fetch_q;
	logic load_last_q;

	assign points.ready = (state_q == ST_LOAD) && !load_last_q && !out_valid_q;
	assign accept = points.valid && points.ready;

	always_comb begin
		if (state_q == ST_FETCH) begin
			addr_a = best_i_q;
			addr_b = best_j_q;
		end else begin
			addr_a = i_q;
			addr_b = j_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (count_q < CntW'(MAX_POINTS)))
			mem[count_q[IdxW-1:0]] <= {points.data.point_y, points.data.point_x};
		rd_a_s1 <= mem[addr_a];
		rd_b_s1 <= mem[addr_b];
	end

	always_comb begin
		dx = 17'(signed'(rd_a_s1[15:0])) - 17'(signed'(rd_b_s1[15:0]));
		dy = 17'(signed'(rd_a_s1[31:16])) - 17'(signed'(rd_b_s1[31:16]));
		ax = dx[16] ? 17'(-dx) : 17'(dx);
		ay = dy[16] ? 17'(-dy) : 17'(dy);
	end

	always_ff @(posedge clk) begin
		pi_s1 <= i_q;
		pj_s1 <= j_q;
		pi_s2 <= pi_s1;
		pj_s2 <= pj_s1;
		dsq_s2 <= 33'(34'(ax) * 34'(ax)) + 33'(34'(ay) * 34'(ay));
	end

	assign root_start = (state_q == ST_FETCH) && (fetch_q == 2'd1);

	cpf_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(root_start),
		.value(best_q[32:0]),
		.done(root_done),
		.root(root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			overflow_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			pv_s1 <= 1'b0;
			pv_s2 <= 1'b0;
			best_q <= '1;
			best_i_q <= '0;
			best_j_q <= '0;
			drain_q <= '0;
			out_valid_q <= 1'b0;
			fetch_q <= '0;
			load_last_q <= 1'b0;
		end else begin
			pv_s1 <= (state_q == ST_SCAN);
			pv_s2 <= pv_s1;
			if (pv_s2 && ({1'b0, dsq_s2} < best_q)) begin
				best_q <= {1'b0, dsq_s2};
				best_i_q <= pi_s2;
				best_j_q <= pj_s2;
			end
			if (out_valid_q && result.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (count_q < CntW'(MAX_POINTS))
							count_q <= count_q + CntW'(1);
						else
							overflow_q <= 1'b1;
						if (points.data.last_point)
							load_last_q <= 1'b1;
					end
					if (load_last_q) begin
						load_last_q <= 1'b0;
						if (count_q < CntW'(2)) begin
							out_q <= '{first_x: '0, first_y: '0, second_x: '0,
								second_y: '0, dist_sq: '0, dist_root: '0,
								status: STATUS_FEW};
							out_valid_q <= 1'b1;
							count_q <= '0;
							overflow_q <= 1'b0;
						end else begin
							best_q <= '1;
							best_i_q <= '0;
							best_j_q <= '0;
							i_q <= '0;
							j_q <= IdxW'(1);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (CntW'(j_q) == count_q - CntW'(1)) begin
						if (CntW'(i_q) == count_q - CntW'(2)) begin
							state_q <= ST_DRAIN;
							drain_q <= '0;
						end else begin
							i_q <= i_q + IdxW'(1);
							j_q <= i_q + IdxW'(2);
						end
					end else begin
						j_q <= j_q + IdxW'(1);
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 3'd1;
					if (drain_q == 3'd2) begin
						state_q <= ST_FETCH;
						fetch_q <= '0;
					end
				end
				ST_FETCH: begin
					fetch_q <= fetch_q + 2'd1;
					if (fetch_q == 2'd1) begin
						out_q.first_x <= rd_a_s1[15:0];
						out_q.first_y <= rd_a_s1[31:16];
						out_q.second_x <= rd_b_s1[15:0];
						out_q.second_y <= rd_b_s1[31:16];
						out_q.dist_sq <= best_q[32:0];
						out_q.status <= overflow_q ? STATUS_OVERFLOW : STATUS_OK;
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (root_done) begin
						out_q.dist_root <= root;
						out_valid_q <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					count_q <= '0;
					overflow_q <= 1'b0;
					state_q <= ST_LOAD;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign result.valid = out_valid_q;
	assign result.data = out_q;

	a_no_load_while_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> !accept) else $error("point taken during scan");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MAX_POINTS)) else $error("point count beyond capacity");
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |=> out_valid_q && $stable(out_q))
		else $error("result changed while stalled");
endmodule

// ===== tb/closest_pair_finder_tb.sv =====
`timescale 1ns / 1ps
module closest_pair_finder_tb;
	import cpf_pkg::*;

	localparam int NumPoints = 64;
	localparam longint CycleLimit = 4000000;

	class pair_scoreboard;
		point_word_t held[$];
		bit overflow;
		result_word_t pending[$];
		int errors;

		function void note_point(point_word_t w);
			logic [33:0] best;
			logic [33:0] d;
			logic signed [16:0] dx;
			logic signed [16:0] dy;
			logic [16:0] ax;
			logic [16:0] ay;
			logic [33:0] rem;
			logic [33:0] bit_v;
			logic [33:0] root;
			int bi;
			int bj;
			result_word_t r;
			if (held.size() < NumPoints) held.push_back(w);
			else overflow = 1'b1;
			if (!w.last_point) return;
			r = '0;
			if (held.size() < 2) begin
				r.status = STATUS_FEW;
			end else begin
				best = '1;
				bi = 0;
				bj = 0;
				for (int i = 0; i < held.size(); i++)
					for (int j = i + 1; j < held.size(); j++) begin
						dx = held[i].point_x - held[j].point_x;
						dy = held[i].point_y - held[j].point_y;
						ax = dx < 0 ? -dx : dx;
						ay = dy < 0 ? -dy : dy;
						d = 34'(ax) * 34'(ax) + 34'(ay) * 34'(ay);
						if (d < best) begin
							best = d;
							bi = i;
							bj = j;
						end
					end
				// Bitwise integer square root, two bits of the operand per step.
				rem = best;
				root = 0;
				bit_v = 34'h1 << 32;
				while (bit_v > rem) bit_v = bit_v >> 2;
				while (bit_v != 0) begin
					if (rem >= root + bit_v) begin
						rem = rem - (root + bit_v);
						root = (root >> 1) + bit_v;
					end else begin
						root = root >> 1;
					end
					bit_v = bit_v >> 2;
				end
				r.first_x = held[bi].point_x;
				r.first_y = held[bi].point_y;
				r.second_x = held[bj].point_x;
				r.second_y = held[bj].point_y;
				r.dist_sq = best[32:0];
				r.dist_root = root[16:0];
				r.status = overflow ? STATUS_OVERFLOW : STATUS_OK;
			end
			pending.push_back(r);
			held.delete();
			overflow = 1'b0;
		endfunction

		task report(string what, longint got, longint want);
			$display("mismatch %s: got %0d expected %0d", what, got, want);
			errors++;
		endtask

		task check_result(result_word_t g);
			result_word_t e;
			if (pending.size() == 0) begin
				report("unexpected result words", 1, 0);
				return;
			end
			e = pending.pop_front();
			if (g.first_x !== e.first_x) report("first_x", g.first_x, e.first_x);
			if (g.first_y !== e.first_y) report("first_y", g.first_y, e.first_y);
			if (g.second_x !== e.second_x) report("second_x", g.second_x, e.second_x);
			if (g.second_y !== e.second_y) report("second_y", g.second_y, e.second_y);
			if (g.dist_sq !== e.dist_sq) report("dist_sq", g.dist_sq, e.dist_sq);
			if (g.dist_root !== e.dist_root) report("dist_root", g.dist_root, e.dist_root);
			if (g.status !== e.status) report("status", g.status, e.status);
		endtask
	endclass

	logic clk;
	logic arst_n;
	cpf_point_if points();
	cpf_result_if result();
	pair_scoreboard board;
	bit quiet;
	bit hold_off;
	longint cycles;

	closest_pair_finder dut (
		.clk(clk),
		.arst_n(arst_n),
		.points(points.sink),
		.result(result.source)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Valid stays high between back-to-back words and drops only for idle gaps.
	task send_point(logic signed [15:0] x, logic signed [15:0] y, logic last);
		if (!quiet && $urandom_range(3) == 0) begin
			points.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		points.valid <= 1'b1;
		points.data <= '{point_x: x, point_y: y, last_point: last};
		@(posedge clk);
		while (!points.ready) @(posedge clk);
		board.note_point(points.data);
	endtask

	function automatic logic [15:0] rand_coord(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 40)) - 16'd20;
			default: return $urandom_range(1) ? 16'h7fff - 16'($urandom_range(3))
				: 16'h8000 + 16'($urandom_range(3));
		endcase
	endfunction

	task send_set(int n, int mode);
		for (int k = 0; k < n; k++)
			send_point(rand_coord(mode), rand_coord(mode), k == n - 1);
	endtask

	task wait_drained();
		points.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	// Sink side: random stalls, plus one long hold-off commanded by the stimulus.
	initial begin
		result.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result.valid && result.ready) board.check_result(result.data);
			if (hold_off) result.ready <= 1'b0;
			else if (!quiet && $urandom_range(4) == 0) result.ready <= 1'b0;
			else result.ready <= 1'b1;
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		board = new();
		quiet = 1'b0;
		hold_off = 1'b0;
		points.valid <= 1'b0;
		points.data <= '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets: too few points, extremes, ties, a full store and overflow.
		send_point(16'sh7fff, 16'sh8000, 1'b1);
		send_point(16'sh8000, 16'sh8000, 1'b0);
		send_point(16'sh7fff, 16'sh7fff, 1'b1);
		send_point(16'sh8000, 16'sh7fff, 1'b0);
		send_point(16'sh7fff, 16'sh8000, 1'b1);
		send_point(16'sd5, 16'sd5, 1'b0);
		send_point(16'sd5, 16'sd5, 1'b0);
		send_point(16'sd5, 16'sd5, 1'b1);
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(16'sd3, 16'sd4, 1'b0);
		send_point(-16'sd3, -16'sd4, 1'b0);
		send_point(16'sd6, 16'sd8, 1'b1);
		send_set(NumPoints, 0);
		send_set(NumPoints + 3, 1);
		sent = 2 * NumPoints + 15;

		// Long receiver hold-off while the stimulus keeps offering points.
		fork
			begin
				hold_off = 1'b1;
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int s = 0; s < 10; s++) send_set($urandom_range(1, 4), 2);
		join
		wait_drained();
		repeat (20) @(posedge clk);

		while (sent < 900) begin
			int n;
			n = $urandom_range(9) == 0 ? $urandom_range(40, 70) : $urandom_range(0, 12);
			if (sent > 750) quiet = 1'b1;
			send_set(n, $urandom_range(2));
			sent += n;
		end
		wait_drained();
		repeat (100) @(posedge clk);
		if (board.errors == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end
endmodule
